@@ sv/ctrf_pkg.sv @@
// Shared types, character codes and constants of the CSV telemetry record formatter.
package ctrf_pkg;

	localparam int VALUE_W      = 52;
	localparam int TIME_W       = 64;
	localparam int COUNT_W      = 32;
	localparam int SLOT_W       = 3;
	localparam int DIGITS_W     = 4;
	localparam int CFG_W        = 4;
	localparam int COMMA_W      = 6;
	localparam int MAX_CHUNKS   = 15;
	localparam int CHUNK_CNT_W  = 4;
	localparam int BCD_DIGITS   = 20;
	localparam int SCALED_W     = 30;
	localparam int BIN_W        = 64;
	localparam int ITER_W       = 7;

	localparam logic [CFG_W-1:0] SLOTS_RESET = 4'd4;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef struct packed {
		logic [TIME_W-1:0]         elapsed_time_us;
		logic [COUNT_W-1:0]        aggregate_sample_number;
		logic [COUNT_W-1:0]        sensor_sample_number;
		logic [SLOT_W-1:0]         sensor_slot;
		logic [DIGITS_W-1:0]       decimal_digits;
		logic signed [VALUE_W-1:0] value_a;
		logic signed [VALUE_W-1:0] value_b;
		logic signed [VALUE_W-1:0] value_c;
	} in_item_t;

	typedef struct packed {
		logic [63:0] text_chunk;
		logic [3:0]  chunk_bytes;
		logic        last_chunk;
	} out_item_t;

	// Classified record handed from the front to the back.
	typedef struct packed {
		logic [TIME_W-1:0]             elapsed_time_us;
		logic [COUNT_W-1:0]            aggregate_sample_number;
		logic [COUNT_W-1:0]            sensor_sample_number;
		logic [DIGITS_W-1:0]           places;
		logic [COMMA_W-1:0]            lead;
		logic [COMMA_W-1:0]            trail;
		logic [2:0]                    neg;
		logic [2:0][VALUE_W-1:0]       mag;
	} rec_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] code;
	} char_t;

	function automatic logic [SCALED_W-1:0] dec_pow(input logic [DIGITS_W-1:0] n);
		logic [SCALED_W-1:0] p;
		unique case (n)
			4'd0:    p = 30'd1;
			4'd1:    p = 30'd10;
			4'd2:    p = 30'd100;
			4'd3:    p = 30'd1000;
			4'd4:    p = 30'd10000;
			4'd5:    p = 30'd100000;
			4'd6:    p = 30'd1000000;
			4'd7:    p = 30'd10000000;
			4'd8:    p = 30'd100000000;
			4'd9:    p = 30'd1000000000;
			default: p = 30'd1;
		endcase
		return p;
	endfunction

endpackage

@@ sv/ctrf_front.sv @@
// Front part: slot count register, input acceptance and record classification.
module ctrf_front #(
	parameter int MAX_SENSOR_SLOTS = 8,
	parameter int MAX_DECIMALS     = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ctrf_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  ctrf_pkg::in_item_t        in_data,
	input  logic                      q_full,
	output logic                      q_push,
	output ctrf_pkg::rec_t            q_rec
);
	import ctrf_pkg::*;

	localparam logic [4:0]          MAXS = 5'(MAX_SENSOR_SLOTS);
	localparam logic [DIGITS_W-1:0] MAXD = DIGITS_W'(MAX_DECIMALS);

	logic [CFG_W-1:0]         slots_q;
	logic [4:0]               cfg5, eff5, last5, slot5, sl5, diff5;
	logic [2:0][VALUE_W-1:0]  raw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= SLOTS_RESET;
		end else if (cfg_valid) begin
			slots_q <= cfg_data;
		end
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		cfg5 = {1'b0, slots_q};
		if (cfg5 == 5'd0) begin
			eff5 = 5'd1;
		end else if (cfg5 > MAXS) begin
			eff5 = MAXS;
		end else begin
			eff5 = cfg5;
		end
		last5 = eff5 - 5'd1;
		slot5 = {2'b00, in_data.sensor_slot};
		sl5   = (slot5 > last5) ? last5 : slot5;
		diff5 = last5 - sl5;

		raw = {in_data.value_c, in_data.value_b, in_data.value_a};

		q_rec.elapsed_time_us         = in_data.elapsed_time_us;
		q_rec.aggregate_sample_number = in_data.aggregate_sample_number;
		q_rec.sensor_sample_number    = in_data.sensor_sample_number;
		q_rec.places = (in_data.decimal_digits > MAXD) ? MAXD : in_data.decimal_digits;
		q_rec.lead   = COMMA_W'({sl5, 1'b0}) + COMMA_W'(sl5);
		q_rec.trail  = COMMA_W'({diff5, 1'b0}) + COMMA_W'(diff5);
		for (int i = 0; i < 3; i++) begin
			q_rec.neg[i] = raw[i][VALUE_W-1];
			q_rec.mag[i] = raw[i][VALUE_W-1] ? (~raw[i] + VALUE_W'(1)) : raw[i];
		end
	end

endmodule

@@ sv/ctrf_fifo.sv @@
// Two-entry record queue between the front and the back.
module ctrf_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ctrf_pkg::rec_t push_data,
	output logic           full,
	input  logic           pop,
	output ctrf_pkg::rec_t pop_data,
	output logic           not_empty
);
	import ctrf_pkg::*;

	rec_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

@@ sv/ctrf_back.sv @@
// Back part: line sequencer with a shared bit-serial binary to decimal converter.
module ctrf_back #(
	parameter int FRACTION_BITS = 20
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rec_valid,
	input  ctrf_pkg::rec_t rec,
	output logic           rec_pop,
	output ctrf_pkg::char_t ch,
	input  logic           ch_ready
);
	import ctrf_pkg::*;

	localparam int IW = VALUE_W - FRACTION_BITS + 1;
	localparam int PW = FRACTION_BITS + SCALED_W;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_LOAD  = 14'b00000000000010,
		ST_MUL   = 14'b00000000000100,
		ST_RND   = 14'b00000000001000,
		ST_SIGN  = 14'b00000000010000,
		ST_CONV  = 14'b00000000100000,
		ST_INT   = 14'b00000001000000,
		ST_SEP   = 14'b00000010000000,
		ST_LEAD  = 14'b00000100000000,
		ST_DOT   = 14'b00001000000000,
		ST_FRAC  = 14'b00010000000000,
		ST_TRAIL = 14'b00100000000000,
		ST_NL    = 14'b01000000000000
	} state_t;

	state_t                          state_q;
	rec_t                            rec_q;
	logic [2:0]                      fld_q;
	logic [BIN_W-1:0]                bin_q;
	logic [BCD_DIGITS-1:0][3:0]      bcd_q;
	logic [ITER_W-1:0]               it_q;
	logic                            frac_q;
	logic [4:0]                      di_q;
	logic                            started_q;
	logic [3:0]                      lo_q;
	logic [COMMA_W-1:0]              cnt_q;
	logic                            vneg_q;
	logic [IW-1:0]                   ipart_q;
	logic [FRACTION_BITS-1:0]        fpart_q;
	logic [SCALED_W-1:0]             pow_q;
	logic [PW-1:0]                   prod_q;
	logic [SCALED_W-1:0]             scaled_q;

	logic [3:0]                      digit;
	logic                            emit;
	logic [7:0]                      code;
	logic [BCD_DIGITS-1:0][3:0]      adj;
	logic [BCD_DIGITS*4-1:0]         adj_flat;
	logic [3:0]                      lo;
	logic [1:0]                      vidx;
	logic [VALUE_W-1:0]              vmag;
	logic [PW:0]                     rnd;
	logic [SCALED_W:0]               sc;
	logic                            fe_frac;

	assign digit   = bcd_q[di_q];
	assign vidx    = 2'(fld_q - 3'd3);
	assign vmag    = rec_q.mag[vidx];
	assign rnd     = {1'b0, prod_q} + ((PW+1)'(1) << (FRACTION_BITS - 1));
	assign sc      = rnd[PW:FRACTION_BITS];
	assign fe_frac = (fld_q >= 3'd3) && !frac_q && (scaled_q != '0);
	assign rec_pop = (state_q == ST_IDLE) && rec_valid;

	always_comb begin
		emit = 1'b0;
		code = CH_COMMA;
		unique case (state_q)
			ST_SIGN: begin
				emit = vneg_q;
				code = CH_MINUS;
			end
			ST_INT: begin
				emit = started_q || (digit != 4'd0) || (di_q == 5'd0);
				code = CH_ZERO + {4'd0, digit};
			end
			ST_SEP:             emit = 1'b1;
			ST_LEAD, ST_TRAIL:  emit = (cnt_q != '0);
			ST_DOT: begin
				emit = 1'b1;
				code = CH_DOT;
			end
			ST_FRAC: begin
				emit = 1'b1;
				code = CH_ZERO + {4'd0, digit};
			end
			ST_NL: begin
				emit = 1'b1;
				code = CH_NL;
			end
			default: emit = 1'b0;
		endcase
	end

	assign ch.valid = emit;
	assign ch.code  = code;

	// Shift-and-add-three step of the decimal converter, and the lowest nonzero digit of the ten lowest.
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		adj_flat = adj;
		lo = 4'd0;
		for (int i = 9; i >= 0; i--) begin
			if (bcd_q[i] != 4'd0) begin
				lo = 4'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rec_q     <= '0;
			fld_q     <= '0;
			bin_q     <= '0;
			bcd_q     <= '0;
			it_q      <= '0;
			frac_q    <= 1'b0;
			di_q      <= '0;
			started_q <= 1'b0;
			lo_q      <= '0;
			cnt_q     <= '0;
			vneg_q    <= 1'b0;
			ipart_q   <= '0;
			fpart_q   <= '0;
			pow_q     <= '0;
			prod_q    <= '0;
			scaled_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (rec_valid) begin
						rec_q   <= rec;
						fld_q   <= 3'd0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					frac_q <= 1'b0;
					bcd_q  <= '0;
					if (fld_q == 3'd0) begin
						bin_q   <= rec_q.elapsed_time_us;
						it_q    <= ITER_W'(BIN_W);
						state_q <= ST_CONV;
					end else if (fld_q == 3'd1) begin
						bin_q   <= {rec_q.aggregate_sample_number, 32'd0};
						it_q    <= ITER_W'(COUNT_W);
						state_q <= ST_CONV;
					end else if (fld_q == 3'd2) begin
						bin_q   <= {rec_q.sensor_sample_number, 32'd0};
						it_q    <= ITER_W'(COUNT_W);
						state_q <= ST_CONV;
					end else begin
						vneg_q  <= rec_q.neg[vidx];
						ipart_q <= IW'(vmag >> FRACTION_BITS);
						fpart_q <= vmag[FRACTION_BITS-1:0];
						pow_q   <= dec_pow(rec_q.places);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= PW'(fpart_q) * PW'(pow_q);
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (sc >= {1'b0, pow_q}) begin
						ipart_q  <= ipart_q + IW'(1);
						scaled_q <= '0;
					end else begin
						scaled_q <= sc[SCALED_W-1:0];
					end
					state_q <= ST_SIGN;
				end
				ST_SIGN: begin
					if (!vneg_q || ch_ready) begin
						bin_q   <= BIN_W'(ipart_q) << (BIN_W - IW);
						bcd_q   <= '0;
						it_q    <= ITER_W'(IW);
						frac_q  <= 1'b0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (it_q != '0) begin
						bcd_q <= {adj_flat[BCD_DIGITS*4-2:0], bin_q[BIN_W-1]};
						bin_q <= {bin_q[BIN_W-2:0], 1'b0};
						it_q  <= it_q - ITER_W'(1);
					end else begin
						di_q      <= 5'(BCD_DIGITS - 1);
						started_q <= 1'b0;
						state_q   <= frac_q ? ST_DOT : ST_INT;
					end
				end
				ST_INT: begin
					if (!emit || ch_ready) begin
						if (emit) begin
							started_q <= 1'b1;
						end
						if (di_q != 5'd0) begin
							di_q <= di_q - 5'd1;
						end else if (fe_frac) begin
							bin_q   <= BIN_W'(scaled_q) << (BIN_W - SCALED_W);
							bcd_q   <= '0;
							it_q    <= ITER_W'(SCALED_W);
							frac_q  <= 1'b1;
							state_q <= ST_CONV;
						end else if (fld_q == 3'd5) begin
							cnt_q   <= rec_q.trail;
							state_q <= ST_TRAIL;
						end else begin
							state_q <= ST_SEP;
						end
					end
				end
				ST_SEP: begin
					if (ch_ready) begin
						fld_q <= fld_q + 3'd1;
						if (fld_q == 3'd2) begin
							cnt_q   <= rec_q.lead;
							state_q <= ST_LEAD;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LEAD: begin
					if (cnt_q == '0) begin
						state_q <= ST_LOAD;
					end else if (ch_ready) begin
						cnt_q <= cnt_q - COMMA_W'(1);
					end
				end
				ST_DOT: begin
					if (ch_ready) begin
						di_q    <= 5'(rec_q.places) - 5'd1;
						lo_q    <= lo;
						state_q <= ST_FRAC;
					end
				end
				ST_FRAC: begin
					if (ch_ready) begin
						if (di_q != {1'b0, lo_q}) begin
							di_q <= di_q - 5'd1;
						end else if (fld_q == 3'd5) begin
							cnt_q   <= rec_q.trail;
							state_q <= ST_TRAIL;
						end else begin
							state_q <= ST_SEP;
						end
					end
				end
				ST_TRAIL: begin
					if (cnt_q == '0) begin
						state_q <= ST_NL;
					end else if (ch_ready) begin
						cnt_q <= cnt_q - COMMA_W'(1);
					end
				end
				ST_NL: begin
					if (ch_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ sv/ctrf_pack.sv @@
// Packs the character stream into chunks of up to eight bytes with an output register.
module ctrf_pack (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrf_pkg::char_t     ch,
	output logic                ch_ready,
	output logic                out_valid,
	input  logic                out_stall,
	output ctrf_pkg::out_item_t out_data
);
	import ctrf_pkg::*;

	logic [63:0]            acc_q;
	logic [2:0]             cnt_q;
	logic [CHUNK_CNT_W-1:0] chunk_q;
	logic                   drop_q;
	logic                   valid_q;
	out_item_t              out_q;

	logic        take, nl, cap, flush;
	logic [63:0] word;

	assign ch_ready  = !valid_q || !out_stall;
	assign take      = ch.valid && ch_ready;
	assign nl        = (ch.code == CH_NL);
	assign cap       = (chunk_q == CHUNK_CNT_W'(MAX_CHUNKS - 1));
	assign flush     = take && !drop_q && (nl || (cnt_q == 3'd7));
	assign out_valid = valid_q;
	assign out_data  = out_q;

	always_comb begin
		word = acc_q;
		word[{cnt_q, 3'b000} +: 8] = ch.code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cnt_q   <= '0;
			chunk_q <= '0;
			drop_q  <= 1'b0;
			valid_q <= 1'b0;
			out_q   <= '0;
		end else begin
			if (take) begin
				if (drop_q) begin
					if (nl) begin
						drop_q  <= 1'b0;
						chunk_q <= '0;
					end
				end else if (flush) begin
					out_q.text_chunk  <= word;
					out_q.chunk_bytes <= {1'b0, cnt_q} + 4'd1;
					out_q.last_chunk  <= nl || cap;
					acc_q             <= '0;
					cnt_q             <= '0;
					chunk_q           <= nl ? '0 : chunk_q + CHUNK_CNT_W'(1);
					drop_q            <= cap && !nl;
				end else begin
					acc_q <= word;
					cnt_q <= cnt_q + 3'd1;
				end
			end
			if (flush) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/csv_telemetry_record_formatter_unit.sv @@
// Top level of the CSV telemetry record formatter: front, record queue, back and chunk packer.
//
//   channel   direction  handshake                 payload
//   cfg       in         cfg_valid / cfg_ready      cfg_data (sensor_slots)
//   in        in         in_valid / in_stall        in_data (one telemetry record)
//   out       out        out_valid / out_stall      out_data (one text chunk)
//
// A record is processed field by field: the back converts each number to decimal in a
// shared shift-and-add-three unit at one bit per cycle (the counters, then each value's
// integer part, and its fraction only when the rounded fraction is nonzero), then walks
// the 20 digit positions of every integer and issues each other character in turn.
// Reset is asynchronous and active low; it restores the slot count of four and empties the queue.
// The front keeps accepting records into a two-entry queue while the back works, and the
// packer's output register lets the back go on while a finished chunk waits; a chunk held
// by out_stall stops the back at its next character.
module csv_telemetry_record_formatter_unit #(
	parameter int MAX_SENSOR_SLOTS = 8,
	parameter int FRACTION_BITS    = 20,
	parameter int MAX_DECIMALS     = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ctrf_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  ctrf_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output ctrf_pkg::out_item_t        out_data
);
	import ctrf_pkg::*;

	// Front to queue.
	logic  q_push, q_full;
	rec_t  q_rec;
	// Queue to back.
	logic  q_pop, q_not_empty;
	rec_t  q_head;
	// Back to packer: one character per transaction.
	char_t ch;
	logic  ch_ready;

	// The front clamps the slot and the decimals, derives the comma counts and takes each value's
	// sign and magnitude, so the back starts from an already classified record.
	ctrf_front #(
		.MAX_SENSOR_SLOTS(MAX_SENSOR_SLOTS),
		.MAX_DECIMALS    (MAX_DECIMALS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (q_rec)
	);

	ctrf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_rec),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_head),
		.not_empty(q_not_empty)
	);

	// The back walks the line field by field and issues one character per transaction.
	ctrf_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_valid(q_not_empty),
		.rec      (q_head),
		.rec_pop  (q_pop),
		.ch       (ch),
		.ch_ready (ch_ready)
	);

	// The packer collects characters into chunks, flushes on the eighth byte or the newline,
	// and cuts an overlong line after the last allowed chunk.
	ctrf_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch       (ch),
		.ch_ready (ch_ready),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

@@ dv/tb_csv_telemetry_record_formatter_unit.sv @@
// Self-checking testbench of the CSV telemetry record formatter with its own line predictor.
module tb_csv_telemetry_record_formatter_unit;
	import ctrf_pkg::*;

	localparam int MAX_SLOTS = 8;
	localparam int FRAC_BITS = 20;
	localparam int MAX_PLACES = 5;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	// Predictor copy of the slot count register.
	logic [CFG_W-1:0] slot_count_reg = SLOTS_RESET;
	// Chunks predicted but not yet seen at the output, oldest first.
	out_item_t pending_chunks[$];
	int error_count = 0;
	int cycle_count = 0;
	// Idle rates, in percent, for the sender and the receiver.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	csv_telemetry_record_formatter_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// The cycle counter ends a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// Appends the unsigned decimal text of a number to the line.
	function automatic void append_decimal(ref byte line[$], input logic [63:0] num);
		byte digits[$];
		logic [63:0] rest;
		rest = num;
		do begin
			digits.push_front(byte'(8'h30 + rest % 10));
			rest = rest / 10;
		end while (rest != 0);
		foreach (digits[i]) line.push_back(digits[i]);
	endfunction

	// Appends one fixed point value, rounded half-up on its magnitude and trimmed.
	function automatic void append_fixed(ref byte line[$], input logic [VALUE_W-1:0] raw,
			input int places);
		logic [63:0] mag, whole, frac, scaled, pow;
		byte fdig[$];
		bit neg;
		pow = 1;
		for (int i = 0; i < places; i++) pow = pow * 10;
		neg = raw[VALUE_W-1];
		mag = neg ? ((64'd1 << VALUE_W) - {12'd0, raw}) : {12'd0, raw};
		whole = mag >> FRAC_BITS;
		frac = mag & ((64'd1 << FRAC_BITS) - 1);
		scaled = (frac * pow + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (scaled >= pow) begin
			whole++;
			scaled = 0;
		end
		if (neg) line.push_back(CH_MINUS);
		append_decimal(line, whole);
		if (scaled == 0) return;
		for (int i = 0; i < places; i++) begin
			fdig.push_front(byte'(8'h30 + scaled % 10));
			scaled = scaled / 10;
		end
		while (fdig[$] == CH_ZERO) void'(fdig.pop_back());
		line.push_back(CH_DOT);
		foreach (fdig[i]) line.push_back(fdig[i]);
	endfunction

	// Builds the CSV line of one record and queues its chunks.
	function automatic void predict_line(input in_item_t rec);
		byte line[$];
		int slots, slot, places, nchunks, cnt;
		out_item_t chunk;
		slots = slot_count_reg;
		if (slots < 1) slots = 1;
		if (slots > MAX_SLOTS) slots = MAX_SLOTS;
		slot = rec.sensor_slot;
		if (slot > slots - 1) slot = slots - 1;
		places = rec.decimal_digits;
		if (places > MAX_PLACES) places = MAX_PLACES;
		append_decimal(line, rec.elapsed_time_us);
		line.push_back(CH_COMMA);
		append_decimal(line, {32'd0, rec.aggregate_sample_number});
		line.push_back(CH_COMMA);
		append_decimal(line, {32'd0, rec.sensor_sample_number});
		line.push_back(CH_COMMA);
		repeat (3 * slot) line.push_back(CH_COMMA);
		append_fixed(line, rec.value_a, places);
		line.push_back(CH_COMMA);
		append_fixed(line, rec.value_b, places);
		line.push_back(CH_COMMA);
		append_fixed(line, rec.value_c, places);
		repeat (3 * (slots - 1 - slot)) line.push_back(CH_COMMA);
		line.push_back(CH_NL);
		nchunks = (line.size() + 7) / 8;
		if (nchunks > MAX_CHUNKS) nchunks = MAX_CHUNKS;
		for (int k = 0; k < nchunks; k++) begin
			cnt = line.size() - 8 * k;
			if (cnt > 8) cnt = 8;
			chunk = '0;
			for (int i = 0; i < cnt; i++) chunk.text_chunk[8*i +: 8] = line[8*k + i];
			chunk.chunk_bytes = cnt[3:0];
			chunk.last_chunk = (k + 1 == nchunks);
			pending_chunks.push_back(chunk);
		end
	endfunction

	// The receiver stalls at random and checks each accepted chunk against the oldest one due.
	always @(posedge clk) begin
		out_item_t due;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_chunks.size() == 0) begin
					report_mismatch($sformatf("unexpected chunk %h", out_data.text_chunk));
				end else begin
					due = pending_chunks.pop_front();
					if (out_data.text_chunk !== due.text_chunk)
						report_mismatch($sformatf("text_chunk %h, wanted %h",
							out_data.text_chunk, due.text_chunk));
					if (out_data.chunk_bytes !== due.chunk_bytes)
						report_mismatch($sformatf("chunk_bytes %0d, wanted %0d",
							out_data.chunk_bytes, due.chunk_bytes));
					if (out_data.last_chunk !== due.last_chunk)
						report_mismatch($sformatf("last_chunk %b, wanted %b",
							out_data.last_chunk, due.last_chunk));
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Sends one record, idling first at the sender's rate, and predicts its line on acceptance.
	// Valid stays high after acceptance so that a following record can go back to back; it is
	// dropped by an idle cycle or by wait_idle.
	task automatic send_record(input in_item_t rec);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= rec;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_line(rec);
	endtask

	// Waits for every predicted chunk, then lets the back drain before a register write.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_chunks.size() != 0) @(posedge clk);
		repeat (1500) @(posedge clk);
	endtask

	task automatic write_slot_count(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		slot_count_reg = value;
	endtask

	function automatic logic [VALUE_W-1:0] random_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(3))
			0: v = VALUE_W'({$urandom, $urandom});
			1: v = VALUE_W'($signed($urandom_range(2000)) - 1000) << FRAC_BITS;
			2: v = VALUE_W'($signed($urandom_range(4000000)) - 2000000);
			default: v = VALUE_W'($signed({$urandom, $urandom} >> $urandom_range(63)));
		endcase
		return v;
	endfunction

	function automatic in_item_t random_record();
		in_item_t rec;
		rec.elapsed_time_us = {$urandom, $urandom} >> $urandom_range(63);
		rec.aggregate_sample_number = $urandom >> $urandom_range(31);
		rec.sensor_sample_number = $urandom >> $urandom_range(31);
		rec.sensor_slot = SLOT_W'($urandom_range(7));
		rec.decimal_digits = DIGITS_W'($urandom_range(15));
		rec.value_a = random_value();
		rec.value_b = random_value();
		rec.value_c = random_value();
		return rec;
	endfunction

	// Field extremes, every slot and the rounding special cases at the reset slot count.
	task automatic test_directed_records();
		in_item_t rec;
		rec = '0;
		send_record(rec);
		rec = '1;
		send_record(rec);
		rec.elapsed_time_us = '1;
		rec.aggregate_sample_number = '1;
		rec.sensor_sample_number = '1;
		rec.decimal_digits = 4'd15;
		rec.value_a = {1'b1, {(VALUE_W-1){1'b0}}};
		rec.value_b = {1'b0, {(VALUE_W-1){1'b1}}};
		rec.value_c = -52'sd1;
		for (int s = 0; s < 8; s++) begin
			rec.sensor_slot = s[2:0];
			send_record(rec);
		end
		// Rounding carry: 0.99999.. rounds up to the next integer.
		rec.decimal_digits = 4'd2;
		rec.value_a = (52'd1 << FRAC_BITS) - 52'd1;
		rec.value_b = -((52'sd3 << FRAC_BITS) - 52'sd1);
		// Negative zero: a tiny negative rounds to "-0".
		rec.value_c = -52'sd3;
		send_record(rec);
		// Half-up boundary and exact halves at one decimal place.
		rec.decimal_digits = 4'd1;
		rec.value_a = 52'd1 << (FRAC_BITS - 1);
		rec.value_b = 52'd5 << (FRAC_BITS - 2);
		rec.value_c = 52'd3 << (FRAC_BITS - 1);
		send_record(rec);
		for (int d = 0; d < 7; d++) begin
			rec = random_record();
			rec.decimal_digits = d[3:0];
			send_record(rec);
		end
	endtask

	// Random records across the slot counts, including the out-of-range ones.
	task automatic test_random_records(input int count);
		logic [CFG_W-1:0] settings[6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd4};
		foreach (settings[i]) begin
			write_slot_count(settings[i]);
			repeat (count / 6) send_record(random_record());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 21;
		recv_idle_pct = 86;
		test_directed_records();
		test_random_records(120);
		send_idle_pct = 86;
		recv_idle_pct = 21;
		test_random_records(120);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_records(108);
		wait_idle();
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
